// ===== src/bsm_pkg.sv =====
// Package for the bank switch mapper: operation codes, register addresses,
// the item, bank state and result structures. No dependencies.
`default_nettype none

package bsm_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_TICK   = 2'd1,
		OP_CPU_RD = 2'd2,
		OP_PPU_RD = 2'd3
	} op_t;

	// Register addresses, decoded exactly.
	localparam logic [15:0] ADDR_PRG_LOW  = 16'h8000;
	localparam logic [15:0] ADDR_PRG_HIGH = 16'h8001;
	localparam logic [15:0] ADDR_CHR2K_0  = 16'h8002;
	localparam logic [15:0] ADDR_CHR2K_1  = 16'h8003;
	localparam logic [15:0] ADDR_CHR1K_0  = 16'hA000;
	localparam logic [15:0] ADDR_CHR1K_1  = 16'hA001;
	localparam logic [15:0] ADDR_CHR1K_2  = 16'hA002;
	localparam logic [15:0] ADDR_CHR1K_3  = 16'hA003;
	localparam logic [15:0] ADDR_IRQ_CNT  = 16'hC000;
	localparam logic [15:0] ADDR_IRQ_EN   = 16'hC001;
	localparam logic [15:0] ADDR_MIRROR   = 16'hE000;

	localparam int unsigned MIRROR_BIT = 6;
	localparam int unsigned IRQ_EN_BIT = 0;
	localparam logic [7:0]  IRQ_TOP    = 8'hFF;
	localparam logic [7:0]  COUNT_RESET = 8'd8;

	localparam int unsigned PHYS_W = 21;

	typedef struct packed {
		op_t         op;
		logic [15:0] address;
		logic [7:0]  data;
		logic        in_vblank;
	} item_t;

	typedef struct packed {
		logic [7:0]      prg_16k_bank_count;
		logic [7:0]      prg_low;
		logic [7:0]      prg_high;
		logic [1:0][7:0] chr_2k;
		logic [3:0][7:0] chr_1k;
	} bank_state_t;

	typedef struct packed {
		logic              irq_fire;
		logic              mirror_horizontal;
		logic              mapped;
		logic [PHYS_W-1:0] phys_address;
	} result_t;

endpackage

`default_nettype wire

// ===== src/bsm_regfile.sv =====
// Mapper register file: bank registers, mirroring with lock and the IRQ counter.
// Applies one item per update strobe. Depends on bsm_pkg.
`default_nettype none

module bsm_regfile (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [7:0]           cfg_wdata,
	input  wire                 upd,
	input  bsm_pkg::item_t      item,
	output bsm_pkg::bank_state_t banks,
	output logic                irq_fire,
	output logic                mirror_next
);
	import bsm_pkg::*;

	logic [7:0]      count_q;
	logic [7:0]      prg_low_q, prg_high_q;
	logic [1:0][7:0] chr_2k_q;
	logic [3:0][7:0] chr_1k_q;
	logic [7:0]      irq_cnt_q;
	logic            irq_en_q;
	logic            locked_q;
	logic            mirror_q;

	logic [7:0]      prg_low_d, prg_high_d, irq_cnt_d;
	logic [1:0][7:0] chr_2k_d;
	logic [3:0][7:0] chr_1k_d;
	logic            irq_en_d, locked_d;

	always_comb begin
		prg_low_d   = prg_low_q;
		prg_high_d  = prg_high_q;
		chr_2k_d    = chr_2k_q;
		chr_1k_d    = chr_1k_q;
		irq_cnt_d   = irq_cnt_q;
		irq_en_d    = irq_en_q;
		locked_d    = locked_q;
		mirror_next = mirror_q;
		irq_fire    = 1'b0;
		case (item.op)
			OP_WRITE: begin
				case (item.address)
					ADDR_PRG_LOW: begin
						prg_low_d = item.data;
						if (!locked_q) begin
							mirror_next = item.data[MIRROR_BIT];
						end
					end
					ADDR_PRG_HIGH: prg_high_d = item.data;
					ADDR_CHR2K_0:  chr_2k_d[0] = item.data;
					ADDR_CHR2K_1:  chr_2k_d[1] = item.data;
					ADDR_CHR1K_0:  chr_1k_d[0] = item.data;
					ADDR_CHR1K_1:  chr_1k_d[1] = item.data;
					ADDR_CHR1K_2:  chr_1k_d[2] = item.data;
					ADDR_CHR1K_3:  chr_1k_d[3] = item.data;
					ADDR_IRQ_CNT:  irq_cnt_d = item.data;
					ADDR_IRQ_EN:   irq_en_d = item.data[IRQ_EN_BIT];
					ADDR_MIRROR: begin
						mirror_next = item.data[MIRROR_BIT];
						locked_d    = 1'b1;
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				if (!item.in_vblank && irq_en_q) begin
					if (irq_cnt_q == IRQ_TOP) begin
						irq_fire = 1'b1;
						irq_en_d = 1'b0;
					end else begin
						irq_cnt_d = irq_cnt_q + 8'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= COUNT_RESET;
			prg_low_q  <= 8'd0;
			prg_high_q <= 8'd1;
			chr_2k_q   <= {8'd1, 8'd0};
			chr_1k_q   <= {8'd7, 8'd6, 8'd5, 8'd4};
			irq_cnt_q  <= 8'd0;
			irq_en_q   <= 1'b0;
			locked_q   <= 1'b0;
			mirror_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (upd) begin
				prg_low_q  <= prg_low_d;
				prg_high_q <= prg_high_d;
				chr_2k_q   <= chr_2k_d;
				chr_1k_q   <= chr_1k_d;
				irq_cnt_q  <= irq_cnt_d;
				irq_en_q   <= irq_en_d;
				locked_q   <= locked_d;
				mirror_q   <= mirror_next;
			end
		end
	end

	assign banks.prg_16k_bank_count = count_q;
	assign banks.prg_low            = prg_low_q;
	assign banks.prg_high           = prg_high_q;
	assign banks.chr_2k             = chr_2k_q;
	assign banks.chr_1k             = chr_1k_q;

endmodule

`default_nettype wire

// ===== src/bsm_translate.sv =====
// Address translation for CPU and PPU reads through the current bank registers.
// Purely combinational. Depends on bsm_pkg.
`default_nettype none

module bsm_translate (
	input  bsm_pkg::item_t       item,
	input  bsm_pkg::bank_state_t banks,
	output logic                 mapped,
	output logic [bsm_pkg::PHYS_W-1:0] phys_address
);
	import bsm_pkg::*;

	logic [7:0]  last_bank;
	logic [7:0]  cpu_bank;
	logic [7:0]  chr_bank;

	always_comb begin
		// Fixed banks wrap at 256 like the bank registers themselves.
		last_bank    = {banks.prg_16k_bank_count[6:0], 1'b0} - 8'd1;
		cpu_bank     = 8'd0;
		chr_bank     = 8'd0;
		mapped       = 1'b0;
		phys_address = '0;
		case (item.op)
			OP_CPU_RD: begin
				case (item.address[14:13])
					2'd0:    cpu_bank = banks.prg_low;
					2'd1:    cpu_bank = banks.prg_high;
					2'd2:    cpu_bank = last_bank - 8'd1;
					default: cpu_bank = last_bank;
				endcase
				if (item.address[15]) begin
					mapped       = 1'b1;
					phys_address = {cpu_bank, item.address[12:0]};
				end
			end
			OP_PPU_RD: begin
				if (item.address[15:13] == 3'd0) begin
					mapped = 1'b1;
					if (!item.address[12]) begin
						chr_bank     = banks.chr_2k[item.address[11]];
						phys_address = {2'b00, chr_bank, item.address[10:0]};
					end else begin
						chr_bank     = banks.chr_1k[item.address[11:10]];
						phys_address = {3'b000, chr_bank, item.address[9:0]};
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/bank_switch_mapper_with_scanline_irq.sv =====
// Bank switch mapper with scanline IRQ, top level.
// Path: an accepted transaction is held in the input register, then in the output register.
// Throughput: one transaction per cycle unless m_axis_tready stalls; the input register feeds
// the decode and bank muxes, whose result lands in the output register, so nothing iterates.
// Reset: arst_n clears both stages and restores the power-on bank layout at once.
// Depends on bsm_pkg, bsm_regfile and bsm_translate.
`default_nettype none

module bank_switch_mapper_with_scanline_irq (
	input  wire        clk,
	input  wire        arst_n,
	// Configuration: program ROM size in 16 KB units.
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata,
	// Input stream.
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [31:0] s_axis_tdata,  // address[15:0], data[23:16], in_vblank[24], zero[31:25]
	input  wire [1:0]  s_axis_tuser,  // op[1:0]
	// Result stream.
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata  // irq_fire[0], mirror_horizontal[1], mapped[2],
	                                  // phys_address[23:3]
);
	import bsm_pkg::*;

	// Input register stage.
	logic        valid_s1;
	item_t       item_s1;

	// Output register.
	logic        out_valid_q;
	result_t     res_q;

	logic        advance;
	logic        upd;
	bank_state_t banks;
	logic        irq_fire;
	logic        mirror_next;
	logic        mapped;
	logic [PHYS_W-1:0] phys_address;

	// The item in the first stage moves on whenever the output register is free or is
	// being emptied in this cycle; the input side is ready whenever that stage frees up.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign upd           = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op        <= op_t'(s_axis_tuser);
			item_s1.address   <= s_axis_tdata[15:0];
			item_s1.data      <= s_axis_tdata[23:16];
			item_s1.in_vblank <= s_axis_tdata[24];
		end
	end

	// State changes are committed only as the item leaves the first stage, so items
	// update the registers strictly in their arrival order.
	bsm_regfile u_regfile (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.upd         (upd),
		.item        (item_s1),
		.banks       (banks),
		.irq_fire    (irq_fire),
		.mirror_next (mirror_next)
	);

	// Translation reads the banks as they stand before this item, which matches the
	// fact that a read never changes a bank register.
	bsm_translate u_translate (
		.item         (item_s1),
		.banks        (banks),
		.mapped       (mapped),
		.phys_address (phys_address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			res_q.irq_fire          <= irq_fire;
			res_q.mirror_horizontal <= mirror_next;
			res_q.mapped            <= mapped;
			res_q.phys_address      <= phys_address;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.phys_address, res_q.mapped, res_q.mirror_horizontal,
		res_q.irq_fire};

`ifndef SYNTH
	// A firing tick result never carries a translation.
	a_fire_not_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.irq_fire |-> !res_q.mapped)
		else $error("irq_fire and mapped set together");

	// An unmapped result reports a zero address.
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res_q.mapped |-> res_q.phys_address == '0)
		else $error("unmapped result with non-zero address");

	// An empty output register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A held item in the first stage is never dropped.
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stage one item lost while stalled");
`endif

endmodule

`default_nettype wire
